// ----- sv/roc_pkg.sv -----
// shared types and constants for the roc auc rank sum block
// no dependencies; used by roc_cell, roc_div and roc_auc_rank_sum
package roc_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int PRED_W      = 17;
   localparam int CNT_W       = 11;   // holds 0..MAX_SAMPLES
   localparam int SCORE_W     = 11;   // per-cell pair score, at most 2*(MAX_SAMPLES-1)
   localparam int SUM_W       = 20;   // total pair score, at most 2*P*N
   localparam int DEN_W       = 21;
   localparam int DVD_W       = 37;
   localparam int OUT_W       = 17;
   localparam int FRAC_W      = 16;
   localparam int ITER_W      = 6;

   typedef struct packed {
      logic               label;
      logic [PRED_W-1:0]  pred;
      logic [SCORE_W-1:0] score;
   } cell_type;

   typedef struct packed {
      logic             done;
      logic [OUT_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_ACC,
      ST_AUC,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      ERR_OK     = 2'd0,
      ERR_NO_POS = 2'd1,
      ERR_NO_NEG = 2'd2,
      ERR_OVER   = 2'd3
   } err_type;

endpackage

// ----- sv/roc_cell.sv -----
// one cell of the sample chain: holds a sample and its pair score
// depends on roc_pkg
module roc_cell (
   input  logic              clock,
   input  logic              load,
   input  logic              drain,
   input  roc_pkg::cell_type new_smp,
   input  roc_pkg::cell_type lo_nbr,
   input  logic [roc_pkg::SCORE_W-1:0] hi_score,
   output roc_pkg::cell_type cell_q
);

   roc_pkg::cell_type cell_ff, cell_in;
   logic [roc_pkg::SCORE_W-1:0] contrib;
   logic gt, eq, lt;

   assign gt = lo_nbr.pred > new_smp.pred;
   assign eq = lo_nbr.pred == new_smp.pred;
   assign lt = lo_nbr.pred < new_smp.pred;

   // positive above negative scores 2, a tie scores 1
   always_comb begin
      contrib = '0;
      if (lo_nbr.label && !new_smp.label) begin
         contrib = gt ? roc_pkg::SCORE_W'(2) : (eq ? roc_pkg::SCORE_W'(1) : '0);
      end else if (!lo_nbr.label && new_smp.label) begin
         contrib = lt ? roc_pkg::SCORE_W'(2) : (eq ? roc_pkg::SCORE_W'(1) : '0);
      end
   end

   always_comb begin
      cell_in = cell_ff;
      if (load) begin
         cell_in       = lo_nbr;
         cell_in.score = lo_nbr.score + contrib;
      end else if (drain) begin
         cell_in.score = hi_score;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_q = cell_ff;

endmodule

// ----- sv/roc_div.sv -----
// restoring divider, one quotient bit per cycle, low bits of quotient kept
// depends on roc_pkg
module roc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [roc_pkg::DVD_W-1:0]  dividend,
   input  logic [roc_pkg::DEN_W-1:0]  divisor,
   output roc_pkg::div_rsp_type       rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [roc_pkg::ITER_W-1:0]  cnt_ff, cnt_in;
   logic [roc_pkg::DVD_W-1:0]   dvd_ff, dvd_in;
   logic [roc_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [roc_pkg::DEN_W-1:0]   dsr_ff, dsr_in;
   logic [roc_pkg::OUT_W-1:0]   quot_ff, quot_in;
   logic [roc_pkg::DEN_W:0]     rem_sh, diff;

   assign rem_sh = {rem_ff, dvd_ff[roc_pkg::DVD_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[roc_pkg::DVD_W-2:0], 1'b0};
         if (!diff[roc_pkg::DEN_W]) begin
            rem_in  = diff[roc_pkg::DEN_W-1:0];
            quot_in = {quot_ff[roc_pkg::OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[roc_pkg::DEN_W-1:0];
            quot_in = {quot_ff[roc_pkg::OUT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == roc_pkg::ITER_W'(roc_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// ----- sv/roc_auc_rank_sum.sv -----
// roc auc by mann-whitney pair counting over a chain of sample cells
// sequence: samples load one beat per cycle; after the last beat the cell
//   scores drain, then two 37-step serial divisions run for accuracy and
//   auc; a class error skips the auc division
// throughput: one sample per cycle while loading, one set at a time
// reset: synchronous active-high reset clears counters, fsm and result valid
module roc_auc_rank_sum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // label[0], prediction[17:1], zero fill
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // auc[16:0], accuracy[33:17], error_code[35:34]
);

   localparam int N = roc_pkg::MAX_SAMPLES;

   roc_pkg::state_type state_ff, state_in;

   // set statistics
   logic [roc_pkg::CNT_W-1:0] count_ff, count_in;
   logic [roc_pkg::CNT_W-1:0] pos_ff, pos_in;
   logic [roc_pkg::CNT_W-1:0] corr_ff, corr_in;
   logic                      ovf_ff, ovf_in;
   logic [roc_pkg::CNT_W-1:0] drain_cnt_ff, drain_cnt_in;
   logic [roc_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [2*roc_pkg::CNT_W-1:0] prod_ff;
   logic [roc_pkg::OUT_W-1:0] acc_ff, acc_in;

   // auc quotient held until the result register is free
   logic [roc_pkg::OUT_W-1:0] auc_hold_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;

   logic                          accept, full, load, drain;
   logic                          in_label;
   logic [roc_pkg::PRED_W-1:0]    in_pred;
   logic [roc_pkg::PRED_W:0]      rounded;
   logic                          match;
   logic [roc_pkg::CNT_W-1:0]     neg;
   roc_pkg::err_type              err;
   roc_pkg::cell_type             new_smp;
   roc_pkg::cell_type             cell_q [N];

   // divider hookup
   logic                         div_start;
   logic [roc_pkg::DVD_W-1:0]    div_dvd;
   logic [roc_pkg::DEN_W-1:0]    div_dsr;
   roc_pkg::div_rsp_type         div_rsp;

   assign in_label = req_tdata[0];
   assign in_pred  = req_tdata[17:1];

   assign req_tready = (state_ff == roc_pkg::ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == roc_pkg::CNT_W'(N));
   assign load       = accept && !full;
   assign drain      = (state_ff == roc_pkg::ST_DRAIN);

   // round at one half, ties up; 1.5 and above rounds to 2 and never matches
   assign rounded = ({1'b0, in_pred} + (roc_pkg::PRED_W+1)'(1 << (roc_pkg::FRAC_W-1)))
                    >> roc_pkg::FRAC_W;
   assign match   = (rounded == {{roc_pkg::PRED_W{1'b0}}, in_label});

   assign new_smp.label = in_label;
   assign new_smp.pred  = in_pred;
   assign new_smp.score = '0;

   // chain of cells: new samples enter at cell 0 and move up, scores drain down
   for (genvar i = 0; i < N; i++) begin : g_cell
      roc_pkg::cell_type              lo;
      logic [roc_pkg::SCORE_W-1:0]    hi;
      if (i == 0) begin : g_lo0
         assign lo = new_smp;
      end else begin : g_lon
         assign lo = cell_q[i-1];
      end
      if (i == N-1) begin : g_hitop
         assign hi = '0;
      end else begin : g_hin
         assign hi = cell_q[i+1].score;
      end
      roc_cell u_cell (
         .clock    (clock),
         .load     (load),
         .drain    (drain),
         .new_smp  (new_smp),
         .lo_nbr   (lo),
         .hi_score (hi),
         .cell_q   (cell_q[i])
      );
   end

   roc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .rsp      (div_rsp)
   );

   assign neg = count_ff - pos_ff;

   always_comb begin
      if (pos_ff == '0) begin
         err = roc_pkg::ERR_NO_POS;
      end else if (neg == '0) begin
         err = roc_pkg::ERR_NO_NEG;
      end else if (ovf_ff) begin
         err = roc_pkg::ERR_OVER;
      end else begin
         err = roc_pkg::ERR_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      corr_in      = corr_ff;
      ovf_in       = ovf_ff;
      drain_cnt_in = drain_cnt_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dvd      = {10'b0, corr_ff, 16'b0};
      div_dsr      = {10'b0, count_ff};
      unique case (state_ff)
         roc_pkg::ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
                  pos_in   = pos_ff + roc_pkg::CNT_W'(in_label);
                  corr_in  = corr_ff + roc_pkg::CNT_W'(match);
               end
               if (req_tlast) begin
                  state_in     = roc_pkg::ST_DRAIN;
                  drain_cnt_in = '0;
                  sum_in       = '0;
               end
            end
         end
         roc_pkg::ST_DRAIN: begin
            // cell 0 holds the next score each cycle
            sum_in       = sum_ff + roc_pkg::SUM_W'(cell_q[0].score);
            drain_cnt_in = drain_cnt_ff + 1'b1;
            if (drain_cnt_ff == count_ff - 1'b1) begin
               div_start = 1'b1;
               state_in  = roc_pkg::ST_ACC;
            end
         end
         roc_pkg::ST_ACC: begin
            div_dvd = {1'b0, sum_ff, 16'b0};
            div_dsr = {prod_ff[roc_pkg::DEN_W-2:0], 1'b0};
            if (div_rsp.done) begin
               acc_in = div_rsp.quot;
               if (err == roc_pkg::ERR_NO_POS || err == roc_pkg::ERR_NO_NEG) begin
                  state_in = roc_pkg::ST_OUT;
                  acc_in   = div_rsp.quot;
                  sum_in   = '0;
               end else begin
                  div_start = 1'b1;
                  state_in  = roc_pkg::ST_AUC;
               end
            end
         end
         roc_pkg::ST_AUC: begin
            if (div_rsp.done) begin
               state_in = roc_pkg::ST_OUT;
               sum_in   = '0;
            end
         end
         roc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in       = 1'b1;
               if (err == roc_pkg::ERR_NO_POS || err == roc_pkg::ERR_NO_NEG) begin
                  rsp_data_in[16:0] = '0;
               end else begin
                  rsp_data_in[16:0] = auc_hold_ff;
               end
               rsp_data_in[33:17] = acc_ff;
               rsp_data_in[35:34] = err;
               rsp_data_in[39:36] = '0;
               count_in = '0;
               pos_in   = '0;
               corr_in  = '0;
               ovf_in   = 1'b0;
               state_in = roc_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = roc_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= roc_pkg::ST_LOAD;
         count_ff     <= '0;
         pos_ff       <= '0;
         corr_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         corr_ff      <= corr_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      drain_cnt_ff <= drain_cnt_in;
      sum_ff       <= sum_in;
      acc_ff       <= acc_in;
      prod_ff      <= pos_ff * neg;
      if (state_ff == roc_pkg::ST_AUC && div_rsp.done) begin
         auc_hold_ff <= div_rsp.quot;
      end
      if (state_ff == roc_pkg::ST_OUT) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a degenerate class mix never reports a nonzero auc
   a_err_auc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[35:34] == roc_pkg::ERR_NO_POS ||
                     rsp_tdata[35:34] == roc_pkg::ERR_NO_NEG) |-> rsp_tdata[16:0] == '0)
      else $error("auc nonzero with error code");
   // closing a set stops intake until the result is built
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("intake open after last beat");
   // divider only finishes while a division is awaited
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == roc_pkg::ST_ACC || state_ff == roc_pkg::ST_AUC))
      else $error("divider done outside division states");
`endif

endmodule
